FILE: rtl/core/ist_pkg.sv
// Package for the instance status table: request and result types, slot
// geometry, request kind codes and the engine state type.
// No dependencies; used by ist_engine and instance_status_table_top.
`default_nettype none

package ist_pkg;

	localparam int ENTRIES = 5;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SLOT_W  = 3;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	localparam logic [2:0] KIND_INSERT    = 3'd0;
	localparam logic [2:0] KIND_UPSERT    = 3'd1;
	localparam logic [2:0] KIND_RD_STATUS = 3'd2;
	localparam logic [2:0] KIND_WR_STATUS = 3'd3;
	localparam logic [2:0] KIND_TICK      = 3'd4;
	localparam logic [2:0] KIND_RD_COUNT  = 3'd5;
	localparam logic [2:0] KIND_CLEAR     = 3'd6;
	localparam logic [2:0] KIND_UNUSED    = 3'd7;

	localparam logic [7:0]  BUSY_STATUS = 8'd3;
	localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] instance_id;
		logic [15:0] value;
	} req_t;

	typedef struct packed {
		logic [15:0] count_out;
		logic [7:0]  status_out;
		logic [SLOT_W-1:0] slot;
		logic        table_full;
		logic        written;
		logic        found;
	} res_t;

	typedef struct packed {
		logic [15:0] key;
		logic [15:0] metric;
		logic [7:0]  status;
		logic [15:0] count;
	} entry_t;

	typedef struct packed {
		logic idle;
		logic done;
	} eng_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/core/ist_engine.sv
// Lookup engine: entry memory, per-slot valid and init flags, and the
// slot scan with read-modify-write. Depends on ist_pkg.
`default_nettype none

module ist_engine
	import ist_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire req_t      req,
	input  wire logic      out_free,
	output eng_stat_t      stat,
	output res_t           res
);

	entry_t mem [ENTRIES];
	entry_t rdata_s1;

	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] st_ok_q;
	logic [ENTRIES-1:0] cnt_ok_q;

	state_t state_q, state_d;
	req_t   req_q;
	res_t   res_q, res_d;
	logic   res_load;

	logic [IDX_W-1:0] idx_q;
	logic             issue_q;
	logic             eval_vld_s1;
	logic [IDX_W-1:0] eval_idx_s1;

	logic       hit, free, is_place, decide, miss_end;
	logic       wr_en;
	logic [7:0] eff_st;
	logic [15:0] eff_cnt;
	entry_t     wr_word;
	logic       clear_go;

	// Status and counter read as zero until a slot's first write; the
	// counter flags are dropped again by a clear.
	assign eff_st  = st_ok_q[eval_idx_s1] ? rdata_s1.status : 8'd0;
	assign eff_cnt = cnt_ok_q[eval_idx_s1] ? rdata_s1.count : 16'd0;

	assign is_place = (req_q.kind == KIND_INSERT) || (req_q.kind == KIND_UPSERT);
	assign hit      = valid_q[eval_idx_s1] && (rdata_s1.key == req_q.instance_id);
	assign free     = !valid_q[eval_idx_s1];
	assign decide   = (state_q == ST_SCAN) && eval_vld_s1 && (hit || (is_place && free));
	assign miss_end = (state_q == ST_SCAN) && eval_vld_s1 && !decide
		&& (eval_idx_s1 == LAST_IDX);

	assign clear_go = start && (req.kind == KIND_CLEAR);

	always_comb begin
		wr_word        = rdata_s1;
		wr_word.status = eff_st;
		wr_word.count  = eff_cnt;
		wr_en          = 1'b0;
		case (req_q.kind)
			KIND_INSERT: begin
				wr_en          = !hit;
				wr_word.key    = req_q.instance_id;
				wr_word.metric = req_q.value;
				wr_word.status = 8'd0;
			end
			KIND_UPSERT: begin
				wr_en          = 1'b1;
				wr_word.key    = req_q.instance_id;
				wr_word.metric = req_q.value;
			end
			KIND_WR_STATUS: begin
				wr_en          = 1'b1;
				wr_word.status = req_q.value[7:0];
			end
			KIND_TICK: begin
				wr_en = 1'b1;
				if (eff_st == BUSY_STATUS) begin
					wr_word.count = (eff_cnt == COUNT_MAX) ? eff_cnt : eff_cnt + 16'd1;
				end else begin
					wr_word.count = 16'd0;
				end
			end
			default: wr_en = 1'b0;
		endcase
		wr_en = wr_en && decide;
	end

	always_comb begin
		res_d = '0;
		if (decide) begin
			res_d.found   = hit;
			res_d.written = wr_en;
			res_d.slot    = SLOT_W'(eval_idx_s1);
			if (req_q.kind == KIND_RD_STATUS) begin
				res_d.status_out = eff_st;
			end
			if (req_q.kind == KIND_RD_COUNT) begin
				res_d.count_out = eff_cnt;
			end
		end else if (miss_end) begin
			res_d.table_full = is_place;
		end
		res_load = start || decide || miss_end;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (req.kind) inside
						KIND_CLEAR, KIND_UNUSED: state_d = ST_DONE;
						default:                 state_d = ST_SCAN;
					endcase
				end
			end
			ST_SCAN: begin
				if (decide || miss_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			issue_q     <= 1'b0;
			eval_vld_s1 <= 1'b0;
			eval_idx_s1 <= '0;
			valid_q     <= '0;
			st_ok_q     <= '0;
			cnt_ok_q    <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				idx_q       <= '0;
				issue_q     <= 1'b1;
				eval_vld_s1 <= 1'b0;
			end else if (state_q == ST_SCAN && !decide && issue_q) begin
				eval_vld_s1 <= 1'b1;
				eval_idx_s1 <= idx_q;
				idx_q       <= idx_q + IDX_W'(1);
				issue_q     <= (idx_q != LAST_IDX);
			end else begin
				eval_vld_s1 <= 1'b0;
				issue_q     <= 1'b0;
			end
			if (clear_go) begin
				valid_q  <= '0;
				cnt_ok_q <= '0;
			end else if (wr_en) begin
				valid_q[eval_idx_s1]  <= 1'b1;
				st_ok_q[eval_idx_s1]  <= 1'b1;
				cnt_ok_q[eval_idx_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[eval_idx_s1] <= wr_word;
		end
		rdata_s1 <= mem[idx_q];
		if (start) begin
			req_q <= req;
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign stat.idle = (state_q == ST_IDLE);
	assign stat.done = (state_q == ST_DONE) && out_free;
	assign res       = res_q;

endmodule

`default_nettype wire

FILE: rtl/core/instance_status_table_top.sv
// A lookup word compares one slot per cycle on the entry memory's single read
// port until it hits, finds a free slot for a placing kind, or passes the last
// slot; clear and unused kinds skip the scan. One word is in work at a time,
// so the next word is taken once the result has moved to the output register;
// that move waits while the output stalls.
// Reset (arst_n low) empties every slot and zeroes status and counters through
// per-slot flags; the entry memory itself is not swept.
// Depends on ist_pkg and ist_engine.
`default_nettype none

module instance_status_table_top
	import ist_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // [15:0] instance_id, [31:16] value
	input  wire logic [2:0]  s_tuser,  // [2:0] kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata   // [0] found, [1] written, [2] table_full,
	                                   // [5:3] slot, [13:6] status_out,
	                                   // [29:14] count_out, [31:30] zero
);

	eng_stat_t stat;
	res_t      res;
	req_t      req;
	logic      start;
	logic      out_free;
	logic      m_tvalid_q;
	logic [31:0] m_tdata_q;

	assign req.kind        = s_tuser;
	assign req.instance_id = s_tdata[15:0];
	assign req.value       = s_tdata[31:16];

	assign s_tready = stat.idle;
	assign start    = s_tvalid && stat.idle;
	assign out_free = !m_tvalid_q || m_tready;

	ist_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.out_free (out_free),
		.stat     (stat),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (stat.done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			m_tdata_q <= {2'b00, res};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/ist_checker.sv
// Port-level checks for the instance status table top level, and the bind
// that attaches them. Depends on instance_status_table_top.
`default_nettype none

module ist_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);

	// A stalled result word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// One request at a time: an accepted word closes the input in the cycle after it.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again right after a request");

	// A full table means nothing matched and nothing was written.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> !m_tdata[0] && !m_tdata[1] && m_tdata[5:3] == 3'd0)
		else $error("table full flagged with a hit or a write");

	// A write never returns read data.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[13:6] == 8'd0 && m_tdata[29:14] == 16'd0)
		else $error("write request returned read data");

endmodule

bind instance_status_table_top ist_checker u_ist_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
